### design/ppf_pkg.sv
// ppf_pkg: shared types and constants of the progress percent formatter
// used by ppf_div and progress_percent_formatter_unit
package ppf_pkg;

  localparam int TEXT_CHARS = 6;
  localparam int DIV_W      = 40;   // dividend and quotient width
  localparam int DVS_W      = 32;   // divisor width
  localparam int CNT_W      = 6;    // iteration count width

  // result status codes
  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_SAME    = 2'd1;
  localparam logic [1:0] ST_UPDATED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP  = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_LOW   = 2'd2;
  localparam logic [1:0] CFG_HIGH  = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BLANK = 8'h20;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;     // quotient bits to produce
    logic [DIV_W-1:0] dividend;  // left aligned: top iters bits are used
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;  // low iters bits are the quotient
  } div_rsp_t;

endpackage

### design/ppf_div.sv
// ppf_div: shared restoring divider, one quotient bit per cycle
// depends on ppf_pkg
module ppf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ppf_pkg::div_req_t req,
  output ppf_pkg::div_rsp_t rsp
);
  import ppf_pkg::*;

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;

  always_comb begin
    shifted = {rem_r, q_r[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    if (!diff[DVS_W+1]) begin
      rem_nxt = diff[DVS_W-1:0];
      q_nxt   = {q_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DVS_W-1:0];
      q_nxt   = {q_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
        rem_r  <= '0;
        q_r    <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

### design/progress_percent_formatter_unit.sv
// progress_percent_formatter_unit: top level, sequencer around the shared divider
// depends on ppf_pkg and ppf_div
//
// One transaction in gives exactly one transaction out. A raw value (tuser 0) is
// rounded to a multiple of step_size; a position (tuser 1) is scaled against
// range_low..range_high into 100/step_size partitions, rounded, clamped, and the
// next position at which the percentage changes is reported as well. A changed
// value is stored and sent as right-aligned decimal ascii. All divisions run on
// one restoring divider that yields one quotient bit a cycle, so the item time is
// set by that unit: a raw value needs the rounding division and, when the value
// changes, the digit steps; a position adds the partition count, the scaling and
// the next-position division. in_tready is high only while the sequencer is
// idle; the result sits in an output register so the next item may be accepted
// while it waits.
module progress_percent_formatter_unit #(
  parameter int MAX_DIGITS = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // value[31:0]
  input  logic         in_tuser,   // command
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // shown_value[31:0], text[79:32],
                                   // text_length[82:80], next_position[116:83]
  output logic [2:0]   out_tuser,  // status[1:0], next_valid[2]
  // configuration
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import ppf_pkg::*;

  // digits actually produced
  localparam int DIG_N = (MAX_DIGITS < TEXT_CHARS) ? MAX_DIGITS : TEXT_CHARS;

  typedef enum logic [3:0] {
    S_IDLE, S_PDIV, S_MUL_OFF, S_PCT_GO, S_PCT, S_RND_GO, S_RND, S_MUL_R,
    S_CMP, S_DIG_M, S_DIG_S, S_MUL_NP, S_NXT_GO, S_NXT, S_DONE
  } state_t;

  // configuration registers
  logic [6:0]         step_r;
  logic [2:0]         width_r;
  logic signed [31:0] low_r, high_r;

  state_t             state_r;
  logic               cmd_r;
  logic [31:0]        range_r;
  logic signed [33:0] off_r;
  logic [6:0]         parts_r;
  logic signed [41:0] prod_r;
  logic [32:0]        nv_r;
  logic [32:0]        qr_r;
  logic [39:0]        rfull_r;
  logic [31:0]        last_r;
  logic [31:0]        x_r;
  logic [28:0]        q10_r;
  logic [2:0]         dig_r;
  logic [3:0]         digit_r [TEXT_CHARS];
  logic               nz_r [TEXT_CHARS];
  logic [1:0]         status_r;
  logic               nvld_r;
  logic signed [33:0] next_r;
  div_req_t           div_req_r;
  div_rsp_t           div_rsp;

  logic               out_tvalid_r;
  logic [119:0]       out_tdata_r;
  logic [2:0]         out_tuser_r;

  // combinational helpers
  logic signed [41:0] pct_num;
  logic [39:0]        part_q;
  logic [6:0]         part;
  logic [31:0]        r_val;
  logic [63:0]        recip;
  logic [32:0]        q10_x10;
  logic [39:0]        nxt_num;
  logic signed [40:0] nxt_sum;
  logic [3:0]         txt_w;
  logic [47:0]        text;

  ppf_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req_r),
    .rsp (div_rsp)
  );

  always_comb begin
    pct_num = prod_r + 42'(range_r >> 1);
    part_q  = div_rsp.quotient;
    part    = (part_q > 40'(parts_r)) ? parts_r : part_q[6:0];
    // rounding past 32 bits falls back one step
    r_val   = (rfull_r[39:32] != 8'd0) ? 32'(rfull_r - 40'(step_r)) : rfull_r[31:0];
    recip   = {32'd0, x_r} * 64'h0000_0000_CCCC_CCCD;
    q10_x10 = {1'b0, q10_r, 3'b000} + {3'b000, q10_r, 1'b0};
    nxt_num = rfull_r - 40'(range_r >> 1) + 40'(parts_r) - 40'd1;
    nxt_sum = $signed({1'b0, div_rsp.quotient}) + 41'(low_r);
    txt_w   = ({1'b0, width_r} > 4'(DIG_N)) ? 4'(DIG_N) : {1'b0, width_r};
    for (int i = 0; i < TEXT_CHARS; i++) begin
      if ((4'(i) < txt_w) && (i == 0 || nz_r[i]))
        text[8*i +: 8] = CH_ZERO + {4'd0, digit_r[i]};
      else
        text[8*i +: 8] = CH_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= 7'd1;
      width_r      <= 3'd3;
      low_r        <= 32'sd0;
      high_r       <= 32'sd100;
      last_r       <= '0;
      state_r      <= S_IDLE;
      div_req_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // start is a one-cycle pulse; no state raises it right after another
      if (div_req_r.start)
        div_req_r.start <= 1'b0;
      // the done state reloads the result register itself
      if (out_tvalid_r && out_tready && state_r != S_DONE)
        out_tvalid_r <= 1'b0;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_STEP:  step_r  <= cfg_data[6:0];
          CFG_WIDTH: width_r <= cfg_data[2:0];
          CFG_LOW:   low_r   <= cfg_data;
          CFG_HIGH:  high_r  <= cfg_data;
          default:   ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r    <= in_tuser;
            nvld_r   <= 1'b0;
            status_r <= ST_IGNORED;
            range_r  <= 32'(high_r - low_r);
            off_r    <= 34'($signed(in_tdata)) - 34'(low_r);
            if (step_r == 7'd0) begin
              state_r <= S_DONE;
            end else if (!in_tuser) begin
              nv_r    <= {1'b0, in_tdata};
              state_r <= S_RND_GO;
            end else if (high_r <= low_r) begin
              state_r <= S_DONE;
            end else begin
              div_req_r <= '{start: 1'b1, iters: CNT_W'(7),
                             dividend: {7'd100, 33'd0}, divisor: 32'(step_r)};
              state_r   <= S_PDIV;
            end
          end
        end
        S_PDIV: begin
          if (div_rsp.done) begin
            parts_r <= div_rsp.quotient[6:0];
            state_r <= (div_rsp.quotient[6:0] == 7'd0) ? S_DONE : S_MUL_OFF;
          end
        end
        S_MUL_OFF: begin
          prod_r  <= 42'(off_r * $signed({1'b0, parts_r}));
          state_r <= S_PCT_GO;
        end
        S_PCT_GO: begin
          if (pct_num < 0) begin
            nv_r    <= '0;
            state_r <= S_RND_GO;
          end else begin
            div_req_r <= '{start: 1'b1, iters: CNT_W'(DIV_W),
                           dividend: pct_num[39:0], divisor: range_r};
            state_r   <= S_PCT;
          end
        end
        S_PCT: begin
          if (div_rsp.done) begin
            nv_r    <= 33'(part * step_r);
            state_r <= S_RND_GO;
          end
        end
        S_RND_GO: begin
          div_req_r <= '{start: 1'b1, iters: CNT_W'(33),
                         dividend: {nv_r + 33'(step_r >> 1), 7'd0},
                         divisor: 32'(step_r)};
          state_r   <= S_RND;
        end
        S_RND: begin
          if (div_rsp.done) begin
            qr_r    <= div_rsp.quotient[32:0];
            state_r <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          rfull_r <= 40'(qr_r * step_r);
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (r_val == last_r) begin
            status_r <= ST_SAME;
            state_r  <= cmd_r ? S_MUL_NP : S_DONE;
          end else begin
            status_r <= ST_UPDATED;
            last_r   <= r_val;
            x_r      <= r_val;
            dig_r    <= '0;
            state_r  <= S_DIG_M;
          end
        end
        S_DIG_M: begin
          q10_r   <= recip[63:35];
          state_r <= S_DIG_S;
        end
        S_DIG_S: begin
          digit_r[dig_r] <= 4'(33'(x_r) - q10_x10);
          nz_r[dig_r]    <= (x_r != 32'd0);
          x_r            <= 32'(q10_r);
          dig_r          <= dig_r + 1'b1;
          if (dig_r == 3'(DIG_N - 1))
            state_r <= cmd_r ? S_MUL_NP : S_DONE;
          else
            state_r <= S_DIG_M;
        end
        S_MUL_NP: begin
          // qr_r is the stored value over the step, at most 100 here
          rfull_r <= 40'(range_r * (qr_r[7:0] + 8'd1));
          state_r <= S_NXT_GO;
        end
        S_NXT_GO: begin
          div_req_r <= '{start: 1'b1, iters: CNT_W'(DIV_W),
                         dividend: nxt_num, divisor: 32'(parts_r)};
          state_r   <= S_NXT;
        end
        S_NXT: begin
          if (div_rsp.done) begin
            next_r  <= nxt_sum[33:0];
            nvld_r  <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= {nvld_r, status_r};
            out_tdata_r  <= {3'd0,
                             nvld_r ? next_r : 34'sd0,
                             (status_r == ST_UPDATED) ? 3'(txt_w) : 3'd0,
                             (status_r == ST_UPDATED) ? text : 48'd0,
                             last_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### design/ppf_checker.sv
// ppf_checker: port-level assertions for progress_percent_formatter_unit
// bound to the top level below; depends on ppf_pkg for the status codes
module ppf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic [2:0]   out_tuser
);
  import ppf_pkg::*;

  // one item at a time: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // text only on an updated display
  a_text_only_updated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_UPDATED |-> out_tdata[82:32] == 51'd0)
    else $error("text present without update");

  // next position never on an ignored item
  a_next_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] != ST_IGNORED)
    else $error("next position on ignored item");

endmodule

bind progress_percent_formatter_unit ppf_checker u_ppf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
